// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the RTL top level; they compile to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hw/rtl/cbaf_pkg.sv
// ---------------------------------------------------------------------------
// cbaf_pkg
// Types, constants and helpers for the content bounding box / aspect fit block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbaf_pkg;

   localparam int MAX_DIMENSION = 4096;

   localparam int DIM_W      = 13;
   localparam int CNT_W      = 12;
   localparam int CH_W       = 8;
   localparam int THR_W      = 9;
   localparam int MARGIN_W   = 11;
   localparam int MODE_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int AREA_W     = DIM_W + 1;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [DIM_W-1:0] MAX_DIM_VAL = DIM_W'(MAX_DIMENSION);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_WIDTH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_HEIGHT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PLACEMENT_MODE  = 3'd6;

   // register reset values
   localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH     = 13'd640;
   localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT    = 13'd480;
   localparam logic [THR_W-1:0]    RST_COLOR_THRESHOLD = 9'd10;
   localparam logic [DIM_W-1:0]    RST_DEST_WIDTH      = 13'd640;
   localparam logic [DIM_W-1:0]    RST_DEST_HEIGHT     = 13'd480;
   localparam logic [MARGIN_W-1:0] RST_MARGIN          = 11'd0;
   localparam logic [MODE_W-1:0]   RST_PLACEMENT_MODE  = 4'd1;

   // placement modes; anything not listed centers
   localparam logic [MODE_W-1:0] PLACE_CENTER       = 4'd1;
   localparam logic [MODE_W-1:0] PLACE_TOP          = 4'd2;
   localparam logic [MODE_W-1:0] PLACE_BOTTOM       = 4'd3;
   localparam logic [MODE_W-1:0] PLACE_LEFT         = 4'd4;
   localparam logic [MODE_W-1:0] PLACE_RIGHT        = 4'd5;
   localparam logic [MODE_W-1:0] PLACE_TOP_LEFT     = 4'd6;
   localparam logic [MODE_W-1:0] PLACE_TOP_RIGHT    = 4'd7;
   localparam logic [MODE_W-1:0] PLACE_BOTTOM_LEFT  = 4'd8;
   localparam logic [MODE_W-1:0] PLACE_BOTTOM_RIGHT = 4'd9;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEGENERATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_ROOM    = 2'd2;

   typedef struct packed {
      logic [CH_W-1:0] pixel_ch0;
      logic [CH_W-1:0] pixel_ch1;
      logic [CH_W-1:0] pixel_ch2;
   } req_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0]    top_edge;
      logic [DIM_W-1:0]    left_edge;
      logic [DIM_W-1:0]    right_edge;
      logic [DIM_W-1:0]    bottom_edge;
      logic [DIM_W-1:0]    fit_width;
      logic [DIM_W-1:0]    fit_height;
      logic [DIM_W-1:0]    place_x;
      logic [DIM_W-1:0]    place_y;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [THR_W-1:0]    color_threshold;
      logic [DIM_W-1:0]    dest_width;
      logic [DIM_W-1:0]    dest_height;
      logic [MARGIN_W-1:0] margin;
      logic [MODE_W-1:0]   placement_mode;
   } cfg_type;

   typedef struct packed {
      logic pix_ready;
      logic latch_edges;
      logic set_fail;
      logic start_div;
      logic flip;
      logic div_step;
      logic take1;
      logic take2;
      logic place;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      logic frame_last;
      logic degenerate;
      logic no_room;
      logic div_last;
      logic over;
      logic out_free;
   } dp_sts_type;

   typedef enum logic [3:0] {
      ST_SCAN,
      ST_EDGE,
      ST_CHECK,
      ST_DIV1,
      ST_TAKE1,
      ST_DIV2,
      ST_TAKE2,
      ST_PLACE,
      ST_DONE
   } cbaf_state_type;

   // 0 reads as 1, anything above the maximum as the maximum
   function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > MAX_DIM_VAL) begin
         r = MAX_DIM_VAL;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/content_bbox_aspect_fit.sv
// ---------------------------------------------------------------------------
// content_bbox_aspect_fit
// Finds the content bounding box of a raster-order RGB frame against the
// first-pixel background, then fits that box into the destination canvas
// with margins and places it. One result word per frame.
//
//   channel  direction  word
//   req_     in         one pixel, three 8-bit channels
//   rsp_     out        edges, fitted size, offset, status
//   csr_     in         register index and write data
//
// Pixels: one per cycle while scanning. After the last pixel of a frame the
// input stalls while the fit runs: the 26-step divider runs once, twice when
// the first quotient overshoots and a second division runs, and not at all for
// the degenerate and no-room cases, plus any wait for the result register.
// Reset is synchronous; the block takes pixels from the first cycle after it.
// A held result does not stall the scan until the next frame end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module content_bbox_aspect_fit
   import cbaf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   ctl_cmd_type cmd;
   dp_sts_type  sts;

   cbaf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cbaf_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   cbaf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign req_ready = cmd.pix_ready;

   `ASSERT_CLK(a_stall_after_frame, clock, reset, (req_valid && req_ready && sts.frame_last) |=> !req_ready)
   `ASSERT_CLK(a_publish_free, clock, reset, cmd.publish |-> sts.out_free)
   `ASSERT_CLK(a_rsp_from_publish, clock, reset, $rose(rsp_valid) |-> $past(cmd.publish))
   `ASSERT_CLK(a_div_needs_room, clock, reset, (cmd.start_div && !cmd.flip) |-> (!sts.degenerate && !sts.no_room))
   `ASSERT_NEVER(a_scan_during_fit, clock, reset, cmd.pix_ready && (cmd.div_step || cmd.publish))

endmodule

`default_nettype wire

// File: hw/rtl/cbaf_csr.sv
// ---------------------------------------------------------------------------
// cbaf_csr
// Configuration register file, written one word at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbaf_csr
   import cbaf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata;
            CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_wdata;
            CSR_COLOR_THRESHOLD: cfg_in.color_threshold = csr_wdata[THR_W-1:0];
            CSR_DEST_WIDTH:      cfg_in.dest_width      = csr_wdata;
            CSR_DEST_HEIGHT:     cfg_in.dest_height     = csr_wdata;
            CSR_MARGIN:          cfg_in.margin          = csr_wdata[MARGIN_W-1:0];
            CSR_PLACEMENT_MODE:  cfg_in.placement_mode  = csr_wdata[MODE_W-1:0];
            default: begin
               // unmapped index: write dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= RST_IMAGE_WIDTH;
         cfg_ff.image_height    <= RST_IMAGE_HEIGHT;
         cfg_ff.color_threshold <= RST_COLOR_THRESHOLD;
         cfg_ff.dest_width      <= RST_DEST_WIDTH;
         cfg_ff.dest_height     <= RST_DEST_HEIGHT;
         cfg_ff.margin          <= RST_MARGIN;
         cfg_ff.placement_mode  <= RST_PLACEMENT_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/cbaf_ctl.sv
// ---------------------------------------------------------------------------
// cbaf_ctl
// Sequencer: pixel scan, then the end-of-frame fit steps and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbaf_ctl
   import cbaf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   input  dp_sts_type sts,
   output ctl_cmd_type cmd
);

   cbaf_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SCAN: begin
            if (req_valid && sts.frame_last) begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.degenerate || sts.no_room) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (sts.div_last) begin
               state_in = ST_TAKE1;
            end
         end
         ST_TAKE1: begin
            if (sts.over) begin
               state_in = ST_DIV2;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_DIV2: begin
            if (sts.div_last) begin
               state_in = ST_TAKE2;
            end
         end
         ST_TAKE2: state_in = ST_PLACE;
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_SCAN:  cmd.pix_ready   = 1'b1;
         ST_EDGE:  cmd.latch_edges = 1'b1;
         ST_CHECK: begin
            if (sts.degenerate || sts.no_room) begin
               cmd.set_fail = 1'b1;
            end else begin
               cmd.start_div = 1'b1;
            end
         end
         ST_DIV1:  cmd.div_step = 1'b1;
         ST_TAKE1: begin
            cmd.take1 = 1'b1;
            // first quotient overshoots: clamp it, solve the other side
            if (sts.over) begin
               cmd.start_div = 1'b1;
               cmd.flip      = 1'b1;
            end
         end
         ST_DIV2:  cmd.div_step = 1'b1;
         ST_TAKE2: cmd.take2    = 1'b1;
         ST_PLACE: cmd.place    = 1'b1;
         ST_DONE:  cmd.publish  = sts.out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SCAN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/cbaf_dp.sv
// ---------------------------------------------------------------------------
// cbaf_dp
// Datapath: content tracking per pixel, shared multiply and bit-serial
// divider for the fit, placement, and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbaf_dp
   import cbaf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   input  req_payload_type req_data,
   input  wire logic      rsp_ready,
   output logic           rsp_valid,
   output rsp_payload_type rsp_data,
   input  cfg_type        cfg,
   input  ctl_cmd_type    cmd,
   output dp_sts_type     sts
);

   function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // scan state
   logic [3*CH_W-1:0] bg_ff, bg_in;
   logic [CNT_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic              seen_ff, seen_in;
   logic [CNT_W-1:0]  min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic [CNT_W-1:0]  min_col_ff, min_col_in, max_col_ff, max_col_in;

   // end-of-frame working registers
   logic [DIM_W-1:0]  top_ff, top_in, left_ff, left_in;
   logic [DIM_W-1:0]  right_ff, right_in, bottom_ff, bottom_in;
   logic [DIM_W-1:0]  cw_ff, cw_in, ch_ff, ch_in;
   logic [AREA_W-1:0] aw_ff, aw_in, ah_ff, ah_in;
   logic              calc_w_ff, calc_w_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [DIM_W-1:0]  den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIM_W-1:0]  fw_ff, fw_in, fh_ff, fh_in;
   logic [DIM_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]  w_eff, h_eff;
   logic              pix_take, first_pix, hit;
   logic [3*CH_W-1:0] pix_word, bg_eff;
   logic [DIM_W-1:0]  col_plus, row_plus;
   logic              row_end, frame_last;
   logic [DIM_W-1:0]  aw_mag, ah_mag;
   logic              calc_new;
   logic [DIM_W-1:0]  mul_a, mul_b, den_new;
   logic [PROD_W-1:0] product;
   logic [AREA_W-1:0] rem_sh;
   logic              rem_ge;
   logic              over;
   logic [DIM_W-1:0]  dx, dy, sel_x, sel_y;

   assign w_eff     = clamp_size(cfg.image_width);
   assign h_eff     = clamp_size(cfg.image_height);
   assign pix_take  = cmd.pix_ready && req_valid;
   assign pix_word  = {req_data.pixel_ch2, req_data.pixel_ch1, req_data.pixel_ch0};
   assign first_pix = (col_ff == '0) && (row_ff == '0);
   assign bg_eff    = first_pix ? pix_word : bg_ff;

   assign hit =
      ({1'b0, abs_diff(bg_eff[CH_W-1:0], req_data.pixel_ch0)} >= cfg.color_threshold) ||
      ({1'b0, abs_diff(bg_eff[2*CH_W-1:CH_W], req_data.pixel_ch1)}
         >= cfg.color_threshold) ||
      ({1'b0, abs_diff(bg_eff[3*CH_W-1:2*CH_W], req_data.pixel_ch2)}
         >= cfg.color_threshold);

   assign col_plus   = {1'b0, col_ff} + DIM_W'(1);
   assign row_plus   = {1'b0, row_ff} + DIM_W'(1);
   assign row_end    = !(col_plus < w_eff);
   assign frame_last = row_end && !(row_plus < h_eff);

   // pixel scan
   always_comb begin
      bg_in      = bg_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      seen_in    = seen_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      if (pix_take) begin
         if (first_pix) begin
            bg_in = pix_word;
         end
         if (hit) begin
            if (!seen_ff) begin
               seen_in    = 1'b1;
               min_row_in = row_ff;
            end
            max_row_in = row_ff;
            if (col_ff < min_col_ff) begin
               min_col_in = col_ff;
            end
            if (col_ff > max_col_ff) begin
               max_col_in = col_ff;
            end
         end
         if (row_end) begin
            col_in = '0;
            if (!frame_last) begin
               row_in = row_plus[CNT_W-1:0];
            end
         end else begin
            col_in = col_plus[CNT_W-1:0];
         end
      end else if (cmd.latch_edges) begin
         bg_in      = '0;
         col_in     = '0;
         row_in     = '0;
         seen_in    = 1'b0;
         min_row_in = '0;
         max_row_in = '0;
         min_col_in = '1;
         max_col_in = '0;
      end
   end

   // fit: shared multiplier feeds a restoring divider, one quotient bit a cycle
   assign aw_mag   = aw_ff[DIM_W-1:0];
   assign ah_mag   = ah_ff[DIM_W-1:0];
   assign calc_new = cmd.flip ? !calc_w_ff : (ch_ff > cw_ff);
   assign mul_a    = calc_new ? ah_mag : aw_mag;
   assign mul_b    = calc_new ? cw_ff : ch_ff;
   assign den_new  = calc_new ? ch_ff : cw_ff;
   assign product  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign rem_sh   = {rem_ff, quo_ff[PROD_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, den_ff};
   assign over     = calc_w_ff ? (quo_ff > PROD_W'(aw_mag)) : (quo_ff > PROD_W'(ah_mag));

   assign dx = aw_mag - fw_ff;
   assign dy = ah_mag - fh_ff;

   always_comb begin
      unique case (cfg.placement_mode)
         PLACE_TOP:          begin sel_x = dx >> 1; sel_y = '0;      end
         PLACE_BOTTOM:       begin sel_x = dx >> 1; sel_y = dy;      end
         PLACE_LEFT:         begin sel_x = '0;      sel_y = dy >> 1; end
         PLACE_RIGHT:        begin sel_x = dx;      sel_y = dy >> 1; end
         PLACE_TOP_LEFT:     begin sel_x = '0;      sel_y = '0;      end
         PLACE_TOP_RIGHT:    begin sel_x = dx;      sel_y = '0;      end
         PLACE_BOTTOM_LEFT:  begin sel_x = '0;      sel_y = dy;      end
         PLACE_BOTTOM_RIGHT: begin sel_x = dx;      sel_y = dy;      end
         default:            begin sel_x = dx >> 1; sel_y = dy >> 1; end
      endcase
   end

   always_comb begin
      top_in    = top_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      bottom_in = bottom_ff;
      cw_in     = cw_ff;
      ch_in     = ch_ff;
      aw_in     = aw_ff;
      ah_in     = ah_ff;
      calc_w_in = calc_w_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      fw_in     = fw_ff;
      fh_in     = fh_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      status_in = status_ff;

      if (cmd.latch_edges) begin
         if (seen_ff) begin
            top_in    = {1'b0, min_row_ff};
            left_in   = {1'b0, min_col_ff};
            right_in  = {1'b0, max_col_ff};
            bottom_in = {1'b0, max_row_ff};
            cw_in     = {1'b0, max_col_ff} - {1'b0, min_col_ff};
            ch_in     = {1'b0, max_row_ff} - {1'b0, min_row_ff};
         end else begin
            top_in    = '0;
            left_in   = '0;
            right_in  = w_eff;
            bottom_in = h_eff;
            cw_in     = w_eff;
            ch_in     = h_eff;
         end
         aw_in = {1'b0, cfg.dest_width} - {2'b00, cfg.margin, 1'b0};
         ah_in = {1'b0, cfg.dest_height} - {2'b00, cfg.margin, 1'b0};
      end

      if (cmd.set_fail) begin
         fw_in     = '0;
         fh_in     = '0;
         px_in     = '0;
         py_in     = '0;
         status_in = sts.degenerate ? STATUS_DEGENERATE : STATUS_NO_ROOM;
      end

      if (cmd.take1) begin
         fw_in = calc_w_ff ? (over ? aw_mag : quo_ff[DIM_W-1:0]) : aw_mag;
         fh_in = calc_w_ff ? ah_mag : (over ? ah_mag : quo_ff[DIM_W-1:0]);
      end

      if (cmd.take2) begin
         if (calc_w_ff) begin
            fw_in = quo_ff[DIM_W-1:0];
         end else begin
            fh_in = quo_ff[DIM_W-1:0];
         end
      end

      if (cmd.start_div) begin
         calc_w_in = calc_new;
         quo_in    = product;
         rem_in    = '0;
         den_in    = den_new;
         cnt_in    = DIV_CNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? DIM_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DIM_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], rem_ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end

      if (cmd.place) begin
         px_in     = sel_x + {2'b00, cfg.margin};
         py_in     = sel_y + {2'b00, cfg.margin};
         status_in = STATUS_OK;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.publish) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.top_edge    = top_ff;
         rsp_data_in.left_edge   = left_ff;
         rsp_data_in.right_edge  = right_ff;
         rsp_data_in.bottom_edge = bottom_ff;
         rsp_data_in.fit_width   = fw_ff;
         rsp_data_in.fit_height  = fh_ff;
         rsp_data_in.place_x     = px_ff;
         rsp_data_in.place_y     = py_ff;
         rsp_data_in.status      = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      sts.frame_last = frame_last;
      sts.degenerate = (cw_ff == '0) && (ch_ff == '0);
      sts.no_room    = aw_ff[AREA_W-1] || (aw_ff == '0) || ah_ff[AREA_W-1] || (ah_ff == '0);
      sts.div_last   = (cnt_ff == DIV_CNT_W'(1));
      sts.over       = over;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         seen_ff      <= 1'b0;
         min_row_ff   <= '0;
         max_row_ff   <= '0;
         min_col_ff   <= '1;
         max_col_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         seen_ff      <= seen_in;
         min_row_ff   <= min_row_in;
         max_row_ff   <= max_row_in;
         min_col_ff   <= min_col_in;
         max_col_ff   <= max_col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bg_ff       <= bg_in;
      top_ff      <= top_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      bottom_ff   <= bottom_in;
      cw_ff       <= cw_in;
      ch_ff       <= ch_in;
      aw_ff       <= aw_in;
      ah_ff       <= ah_in;
      calc_w_ff   <= calc_w_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      fw_ff       <= fw_in;
      fh_ff       <= fh_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for content_bbox_aspect_fit. Frames of pixel words go
// in with random gaps; a tracker class mirrors the bounding box search and
// the fit arithmetic, queues one expected result word per frame and checks
// each returned word field by field. Register settings change between
// frames, with the size, threshold, margin and placement extremes included.
// ---------------------------------------------------------------------------

import cbaf_pkg::*;

class bbox_fit_tracker;
   logic [DIM_W-1:0]    img_w, img_h, dst_w, dst_h;
   logic [THR_W-1:0]    thr;
   logic [MARGIN_W-1:0] mrg;
   logic [MODE_W-1:0]   mode;
   logic [23:0]         bg_color;
   int unsigned         col, row, row_lo, row_hi, col_lo, col_hi;
   bit                  seen;
   rsp_payload_type     pending_fits[$];
   int unsigned         errors, fits_seen;

   function new();
      img_w = RST_IMAGE_WIDTH;
      img_h = RST_IMAGE_HEIGHT;
      thr = RST_COLOR_THRESHOLD;
      dst_w = RST_DEST_WIDTH;
      dst_h = RST_DEST_HEIGHT;
      mrg = RST_MARGIN;
      mode = RST_PLACEMENT_MODE;
      errors = 0;
      fits_seen = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      bg_color = '0;
      col = 0;
      row = 0;
      seen = 0;
      row_lo = 0;
      row_hi = 0;
      col_lo = 32'hFFFF_FFFF;
      col_hi = 0;
   endfunction

   // 0 counts as 1, anything past the maximum as the maximum
   function int unsigned eff_size(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return v;
   endfunction

   function bit channel_marked(int unsigned bgc, int unsigned c);
      int unsigned d;
      d = (bgc > c) ? bgc - c : c - bgc;
      return d >= thr;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IMAGE_WIDTH:     img_w = val;
         CSR_IMAGE_HEIGHT:    img_h = val;
         CSR_COLOR_THRESHOLD: thr = val[THR_W-1:0];
         CSR_DEST_WIDTH:      dst_w = val;
         CSR_DEST_HEIGHT:     dst_h = val;
         CSR_MARGIN:          mrg = val[MARGIN_W-1:0];
         CSR_PLACEMENT_MODE:  mode = val[MODE_W-1:0];
         default: ;
      endcase
   endfunction

   function void take_pixel(req_payload_type pix);
      int unsigned     w, h;
      longint          top, left, right, bottom, cw, ch, aw, ah;
      longint          rw, rh, dx, dy, off_x, off_y;
      rsp_payload_type fit;
      w = eff_size(img_w);
      h = eff_size(img_h);
      if (col == 0 && row == 0) bg_color = {pix.pixel_ch2, pix.pixel_ch1, pix.pixel_ch0};
      if (channel_marked(bg_color[7:0], pix.pixel_ch0) ||
          channel_marked(bg_color[15:8], pix.pixel_ch1) ||
          channel_marked(bg_color[23:16], pix.pixel_ch2)) begin
         if (!seen) begin
            seen = 1;
            row_lo = row;
         end
         row_hi = row;
         if (col < col_lo) col_lo = col;
         if (col > col_hi) col_hi = col;
      end
      if (col + 1 < w) begin
         col++;
         return;
      end
      col = 0;
      if (row + 1 < h) begin
         row++;
         return;
      end

      // frame end
      if (seen) begin
         top = row_lo;
         left = col_lo;
         right = col_hi;
         bottom = row_hi;
      end else begin
         top = 0;
         left = 0;
         right = w;
         bottom = h;
      end
      cw = right - left;
      ch = bottom - top;
      aw = longint'(dst_w) - 2 * longint'(mrg);
      ah = longint'(dst_h) - 2 * longint'(mrg);
      rw = 0;
      rh = 0;
      off_x = 0;
      off_y = 0;
      fit.status = STATUS_OK;
      if (cw == 0 && ch == 0) begin
         fit.status = STATUS_DEGENERATE;
      end else if (aw <= 0 || ah <= 0) begin
         fit.status = STATUS_NO_ROOM;
      end else begin
         if (ch > cw) begin
            rh = ah;
            rw = rh * cw / ch;
            if (rw > aw) begin
               rw = aw;
               rh = rw * ch / cw;
            end
         end else begin
            rw = aw;
            rh = rw * ch / cw;
            if (rh > ah) begin
               rh = ah;
               rw = rh * cw / ch;
            end
         end
         dx = aw - rw;
         dy = ah - rh;
         case (mode)
            PLACE_TOP: begin
               off_x = dx / 2;
               off_y = 0;
            end
            PLACE_BOTTOM: begin
               off_x = dx / 2;
               off_y = dy;
            end
            PLACE_LEFT: begin
               off_x = 0;
               off_y = dy / 2;
            end
            PLACE_RIGHT: begin
               off_x = dx;
               off_y = dy / 2;
            end
            PLACE_TOP_LEFT: begin
               off_x = 0;
               off_y = 0;
            end
            PLACE_TOP_RIGHT: begin
               off_x = dx;
               off_y = 0;
            end
            PLACE_BOTTOM_LEFT: begin
               off_x = 0;
               off_y = dy;
            end
            PLACE_BOTTOM_RIGHT: begin
               off_x = dx;
               off_y = dy;
            end
            default: begin
               off_x = dx / 2;
               off_y = dy / 2;
            end
         endcase
         off_x += mrg;
         off_y += mrg;
      end
      fit.top_edge = top[DIM_W-1:0];
      fit.left_edge = left[DIM_W-1:0];
      fit.right_edge = right[DIM_W-1:0];
      fit.bottom_edge = bottom[DIM_W-1:0];
      fit.fit_width = rw[DIM_W-1:0];
      fit.fit_height = rh[DIM_W-1:0];
      fit.place_x = off_x[DIM_W-1:0];
      fit.place_y = off_y[DIM_W-1:0];
      pending_fits.push_back(fit);
      clear_frame();
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   function void check_fit(rsp_payload_type got);
      rsp_payload_type want;
      fits_seen++;
      if (pending_fits.size() == 0) begin
         errors++;
         if (errors <= 40)
            $display("%0t: unexpected result word, expected none got %h", $time, got);
         return;
      end
      want = pending_fits.pop_front();
      check_field("top_edge", want.top_edge, got.top_edge);
      check_field("left_edge", want.left_edge, got.left_edge);
      check_field("right_edge", want.right_edge, got.right_edge);
      check_field("bottom_edge", want.bottom_edge, got.bottom_edge);
      check_field("fit_width", want.fit_width, got.fit_width);
      check_field("fit_height", want.fit_height, got.fit_height);
      check_field("place_x", want.place_x, got.place_x);
      check_field("place_y", want.place_y, got.place_y);
      check_field("status", want.status, got.status);
   endfunction
endclass

module tb_top;

   localparam int unsigned LIMIT_CYCLES  = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 64;   // covers the longest frame-end pass
   localparam int unsigned END_CYCLES    = 100;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned RANDOM_PIXELS = 1450;
   localparam int unsigned MIN_FITS      = 60;
   localparam int unsigned PRESSURE_PHASE = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam logic [MODE_W-1:0] PLACE_UNLISTED_LOW  = 4'd0;
   localparam logic [MODE_W-1:0] PLACE_UNLISTED_HIGH = 4'd15;

   localparam int unsigned FRAME_BOX   = 0;
   localparam int unsigned FRAME_EMPTY = 1;
   localparam int unsigned FRAME_NOISE = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bbox_fit_tracker tracker = new();
   int unsigned pixels_sent = 0;
   int unsigned cycle_count = 0;
   bit sender_calm = 0;
   bit rx_calm = 0;
   bit hold_request = 0;

   content_bbox_aspect_fit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // returns at the accepting edge with valid still high, so a following
   // word can go back to back
   task automatic send_pixel(input req_payload_type pix);
      int unsigned gap;
      gap = sender_calm ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pix;
      do @(posedge clock); while (!req_ready);
      tracker.take_pixel(pix);
      pixels_sent++;
   endtask

   task automatic stop_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all results in, then let any frame-end pass wind down
   task automatic wait_idle();
      while (tracker.pending_fits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] shifted(int unsigned base, int unsigned lo, int unsigned hi);
      int unsigned d;
      d = $urandom_range(lo, hi);
      if ($urandom_range(0, 1) == 1 && base + d <= 255) return base + d;
      if (base >= d) return base - d;
      if (base + d <= 255) return base + d;
      return $urandom_range(0, 255);
   endfunction

   // channels stay below a nonzero threshold where the offset allows, sometimes right at its edge
   function automatic req_payload_type quiet_pixel(req_payload_type bgp);
      req_payload_type pix;
      int unsigned hi, lo;
      hi = (tracker.thr == 0) ? 0 : ((tracker.thr > 256) ? 255 : tracker.thr - 1);
      lo = ($urandom_range(0, 3) == 0) ? hi : 0;
      pix.pixel_ch0 = shifted(bgp.pixel_ch0, lo, hi);
      pix.pixel_ch1 = shifted(bgp.pixel_ch1, lo, hi);
      pix.pixel_ch2 = shifted(bgp.pixel_ch2, lo, hi);
      return pix;
   endfunction

   function automatic req_payload_type marked_pixel(req_payload_type bgp);
      req_payload_type pix;
      int unsigned lo, hi;
      pix = quiet_pixel(bgp);
      lo = (tracker.thr > 255) ? 255 : tracker.thr;
      hi = ($urandom_range(0, 3) == 0) ? lo : 255;
      case ($urandom_range(0, 2))
         0: pix.pixel_ch0 = shifted(bgp.pixel_ch0, lo, hi);
         1: pix.pixel_ch1 = shifted(bgp.pixel_ch1, lo, hi);
         default: pix.pixel_ch2 = shifted(bgp.pixel_ch2, lo, hi);
      endcase
      return pix;
   endfunction

   task automatic send_frame(input int unsigned w, input int unsigned h,
                             input int unsigned kind);
      req_payload_type bgp, pix;
      logic [23:0] raw;
      int unsigned r0, r1, c0, c1;
      raw = $urandom;
      bgp = raw;
      r0 = $urandom_range(0, h - 1);
      r1 = $urandom_range(r0, h - 1);
      c0 = $urandom_range(0, w - 1);
      c1 = $urandom_range(c0, w - 1);
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            if (kind == FRAME_NOISE) begin
               raw = $urandom;
               pix = raw;
            end else if (r == 0 && c == 0) begin
               pix = bgp;
            end else if (kind == FRAME_BOX && r >= r0 && r <= r1 && c >= c0 && c <= c1 &&
                         $urandom_range(0, 1) == 1) begin
               pix = marked_pixel(bgp);
            end else begin
               pix = quiet_pixel(bgp);
            end
            send_pixel(pix);
         end
      end
   endtask

   function automatic logic [DIM_W-1:0] pick_dest();
      logic [DIM_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = MAX_DIM_VAL;
         1: v = $urandom_range(0, 8191);
         2: v = 1;
         3, 4, 5: v = $urandom_range(1, 32);
         default: v = $urandom_range(1, MAX_DIMENSION);
      endcase
      return v;
   endfunction

   // result side: random stalls, calm stretches, one long hold on request
   initial begin
      int unsigned stall;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            stall = HOLD_CYCLES;
         end else begin
            stall = rx_calm ? 0 : $urandom_range(0, 17);
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_fit(rsp_data);
         if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
      end
   end

   initial begin
      logic [MODE_W-1:0] mode_list[11];
      logic [23:0] raw;
      int unsigned phase, nframes, base, sel, kind, w, h;
      logic [DIM_W-1:0] raw_w, raw_h;
      logic [CSR_DATA_W-1:0] val;

      mode_list[0] = PLACE_UNLISTED_LOW;
      mode_list[1] = PLACE_CENTER;
      mode_list[2] = PLACE_TOP;
      mode_list[3] = PLACE_BOTTOM;
      mode_list[4] = PLACE_LEFT;
      mode_list[5] = PLACE_RIGHT;
      mode_list[6] = PLACE_TOP_LEFT;
      mode_list[7] = PLACE_TOP_RIGHT;
      mode_list[8] = PLACE_BOTTOM_LEFT;
      mode_list[9] = PLACE_BOTTOM_RIGHT;
      mode_list[10] = PLACE_UNLISTED_HIGH;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // zero sizes read as 1x1; zero threshold marks the lone pixel, so the
      // core collapses to a point
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 0);
      write_reg(CSR_IMAGE_HEIGHT, 0);
      write_reg(CSR_COLOR_THRESHOLD, 0);
      write_reg(CSR_DEST_WIDTH, MAX_DIM_VAL);
      write_reg(CSR_DEST_HEIGHT, MAX_DIM_VAL);
      write_reg(CSR_UNUSED, $urandom_range(0, 8191));
      send_pixel('0);
      stop_pixels();

      // threshold out of reach, then at the full channel swing
      for (int t = 0; t < 2; t++) begin
         wait_idle();
         write_reg(CSR_IMAGE_WIDTH, 2);
         write_reg(CSR_IMAGE_HEIGHT, 2);
         write_reg(CSR_COLOR_THRESHOLD, (t == 0) ? 256 : 255);
         send_pixel('0);
         send_pixel('1);
         send_pixel('1);
         send_pixel('1);
         stop_pixels();
      end

      // margins eat the whole destination width
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 1);
      write_reg(CSR_MARGIN, 2047);
      write_reg(CSR_DEST_WIDTH, 4094);
      send_pixel('0);
      send_pixel('0);
      stop_pixels();

      // every placement, with the slack alternating between the two axes
      wait_idle();
      write_reg(CSR_IMAGE_HEIGHT, 1);
      write_reg(CSR_MARGIN, 3);
      write_reg(CSR_DEST_WIDTH, 100);
      for (int m = 0; m < 11; m++) begin
         wait_idle();
         write_reg(CSR_PLACEMENT_MODE, mode_list[m]);
         write_reg(CSR_DEST_HEIGHT, (m % 2 == 1) ? 60 : 200);
         raw = $urandom;
         send_pixel(raw);
         stop_pixels();
      end

      // the largest sizes, once each, over-range values clamped
      sender_calm = 1;
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 8191);
      write_reg(CSR_IMAGE_HEIGHT, 1);
      write_reg(CSR_COLOR_THRESHOLD, 10);
      write_reg(CSR_MARGIN, 0);
      send_frame(MAX_DIMENSION, 1, FRAME_BOX);
      stop_pixels();
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, 1);
      write_reg(CSR_IMAGE_HEIGHT, 5000);
      send_frame(1, MAX_DIMENSION, FRAME_EMPTY);
      stop_pixels();
      sender_calm = 0;

      base = pixels_sent;
      phase = 0;
      while (pixels_sent - base < RANDOM_PIXELS || tracker.fits_seen < MIN_FITS) begin
         wait_idle();
         sel = $urandom_range(0, 15);
         raw_w = (sel == 0) ? 0 : (sel < 3) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         sel = $urandom_range(0, 15);
         raw_h = (sel == 0) ? 0 : (sel < 3) ? $urandom_range(7, 16) : $urandom_range(1, 6);
         write_reg(CSR_IMAGE_WIDTH, raw_w);
         write_reg(CSR_IMAGE_HEIGHT, raw_h);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: val = 0;
               1: val = 1;
               2: val = 255;
               3: val = 256;
               4: val = $urandom_range(0, 8191);
               default: val = $urandom_range(2, 64);
            endcase
            write_reg(CSR_COLOR_THRESHOLD, val);
         end
         if ($urandom_range(0, 3) != 0) write_reg(CSR_DEST_WIDTH, pick_dest());
         if ($urandom_range(0, 3) != 0) write_reg(CSR_DEST_HEIGHT, pick_dest());
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: val = 2047;
               1: val = $urandom_range(0, 8191);
               2, 3: val = $urandom_range(0, 2047);
               default: val = $urandom_range(0, 30);
            endcase
            write_reg(CSR_MARGIN, val);
         end
         if ($urandom_range(0, 3) != 0) write_reg(CSR_PLACEMENT_MODE, $urandom_range(0, 15));

         w = tracker.eff_size(raw_w);
         h = tracker.eff_size(raw_h);
         sender_calm = ($urandom_range(0, 3) == 0);
         nframes = $urandom_range(1, 4);
         // result side stops taking words while frames keep coming
         if (phase == PRESSURE_PHASE) begin
            hold_request = 1;
            nframes = 6;
         end
         repeat (nframes) begin
            sel = $urandom_range(0, 9);
            kind = (sel < 7) ? FRAME_BOX : (sel == 7) ? FRAME_EMPTY : FRAME_NOISE;
            send_frame(w, h, kind);
         end
         stop_pixels();
         phase++;
      end

      while (tracker.pending_fits.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cbaf_pkg.sv
hw/rtl/cbaf_csr.sv
hw/rtl/cbaf_ctl.sv
hw/rtl/cbaf_dp.sv
hw/rtl/content_bbox_aspect_fit.sv
tb/tb_top.sv
